>>> rtl/tms_pkg.sv
// Package for the trigger mode sequencer: widths, register and event codes,
// machine state codes and the state struct. No dependencies.
package tms_pkg;

   // Increment magnitude width and signed increment width
   localparam int INC_WIDTH = 24;
   localparam int PHASE_W   = INC_WIDTH + 1;

   // Register and field widths
   localparam int MODE_W   = 3;
   localparam int EVENT_W  = 3;
   localparam int STATE_W  = 3;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 3;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_TRIG_MODE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_GATE_HOLD = 1'd1;

   // Trigger modes
   localparam logic [MODE_W-1:0] MODE_NORETRIG = 3'd0;
   localparam logic [MODE_W-1:0] MODE_HARDSYNC = 3'd1;
   localparam logic [MODE_W-1:0] MODE_ENVELOPE = 3'd2;
   localparam logic [MODE_W-1:0] MODE_GATE     = 3'd3;
   localparam logic [MODE_W-1:0] MODE_PENDULUM = 3'd4;

   // Phase event codes
   localparam logic [EVENT_W-1:0] EV_A_FROM_ATT = 3'd1;
   localparam logic [EVENT_W-1:0] EV_B_FROM_ATT = 3'd2;
   localparam logic [EVENT_W-1:0] EV_A_FROM_REL = 3'd3;
   localparam logic [EVENT_W-1:0] EV_B_FROM_REL = 3'd4;

   // Two-phase machines (no-retrigger, hard sync)
   localparam logic TWO_ATTACK  = 1'b0;
   localparam logic TWO_RELEASE = 1'b1;

   // Envelope machine
   localparam logic [1:0] ENV_ATTACK    = 2'd0;
   localparam logic [1:0] ENV_RELEASE   = 2'd1;
   localparam logic [1:0] ENV_RETRIGGER = 2'd2;

   // Gate machine
   localparam logic [2:0] GATE_ATTACK      = 3'd0;
   localparam logic [2:0] GATE_REL_REVERSE = 3'd1;
   localparam logic [2:0] GATE_GATED       = 3'd2;
   localparam logic [2:0] GATE_RELEASE     = 3'd3;
   localparam logic [2:0] GATE_RETRIGGER   = 3'd4;

   // Pendulum machine
   localparam logic [2:0] PEND_RESTING     = 3'd0;
   localparam logic [2:0] PEND_FWD_ATTACK  = 3'd1;
   localparam logic [2:0] PEND_REV_ATTACK  = 3'd2;
   localparam logic [2:0] PEND_FWD_RELEASE = 3'd3;
   localparam logic [2:0] PEND_REV_RELEASE = 3'd4;

   // State of all five machines
   typedef struct packed {
      logic       noretrig;
      logic       hardsync;
      logic [1:0] envelope;
      logic [2:0] gate;
      logic [2:0] pendulum;
   } seq_state_type;

endpackage

>>> rtl/tms_step.sv
// One sequencer step: next machine state, signed increment and state index.
// Pure combinational logic; depends on tms_pkg.
module tms_step (
   input  logic [tms_pkg::MODE_W-1:0]    trig_mode,
   input  logic                          gate_hold,
   input  tms_pkg::seq_state_type        cur_state,
   input  logic                          trig_level,
   input  logic [tms_pkg::EVENT_W-1:0]   phase_event,
   input  logic                          osc_active,
   input  logic [tms_pkg::INC_WIDTH-1:0] attack_inc,
   input  logic [tms_pkg::INC_WIDTH-1:0] release_inc,
   output tms_pkg::seq_state_type        next_state,
   output logic [tms_pkg::PHASE_W-1:0]   phase_inc,
   output logic [tms_pkg::STATE_W-1:0]   active_state
);
   import tms_pkg::*;

   logic [PHASE_W-1:0] att_pos;
   logic [PHASE_W-1:0] att_neg;
   logic [PHASE_W-1:0] rel_pos;
   logic [PHASE_W-1:0] rel_neg;
   logic               gate_level;

   // Signed forms of the two increments
   assign att_pos    = {1'b0, attack_inc};
   assign rel_pos    = {1'b0, release_inc};
   assign att_neg    = PHASE_W'(0) - att_pos;
   assign rel_neg    = PHASE_W'(0) - rel_pos;
   assign gate_level = trig_level | gate_hold;

   // Run the selected machine; the others hold
   always_comb begin
      next_state   = cur_state;
      phase_inc    = '0;
      active_state = '0;
      unique case (trig_mode)
         MODE_NORETRIG: begin
            if (cur_state.noretrig == TWO_RELEASE) begin
               if (phase_event == EV_A_FROM_REL) begin
                  next_state.noretrig = TWO_ATTACK;
                  phase_inc = att_pos;
               end else begin
                  phase_inc = rel_pos;
               end
            end else begin
               if (phase_event == EV_B_FROM_ATT) begin
                  next_state.noretrig = TWO_RELEASE;
                  phase_inc = rel_pos;
               end else begin
                  phase_inc = att_pos;
               end
            end
            active_state = STATE_W'(next_state.noretrig);
         end
         MODE_HARDSYNC: begin
            if (cur_state.hardsync == TWO_RELEASE) begin
               // A trigger returns to attack but the release increment still applies
               if (!trig_level) begin
                  next_state.hardsync = TWO_ATTACK;
               end
               if (phase_event == EV_A_FROM_REL) begin
                  next_state.hardsync = TWO_ATTACK;
                  phase_inc = att_pos;
               end else begin
                  phase_inc = rel_pos;
               end
            end else begin
               if (phase_event == EV_B_FROM_ATT) begin
                  next_state.hardsync = TWO_RELEASE;
                  phase_inc = rel_pos;
               end else begin
                  phase_inc = att_pos;
               end
            end
            active_state = STATE_W'(next_state.hardsync);
         end
         MODE_ENVELOPE: begin
            case (cur_state.envelope)
               ENV_RELEASE: begin
                  if (!trig_level) begin
                     next_state.envelope = ENV_RETRIGGER;
                     phase_inc = att_neg;
                  end else if (phase_event == EV_A_FROM_REL) begin
                     next_state.envelope = ENV_ATTACK;
                     phase_inc = att_pos;
                  end else begin
                     phase_inc = rel_pos;
                  end
               end
               ENV_RETRIGGER: begin
                  if (phase_event == EV_B_FROM_REL) begin
                     next_state.envelope = ENV_RELEASE;
                     phase_inc = rel_pos;
                  end else begin
                     phase_inc = att_neg;
                  end
               end
               default: begin
                  next_state.envelope = ENV_ATTACK;
                  if (phase_event == EV_B_FROM_ATT) begin
                     next_state.envelope = ENV_RELEASE;
                     phase_inc = rel_pos;
                  end else begin
                     phase_inc = att_pos;
                  end
               end
            endcase
            active_state = STATE_W'(next_state.envelope);
         end
         MODE_GATE: begin
            case (cur_state.gate)
               GATE_REL_REVERSE: begin
                  if (trig_level || phase_event == EV_A_FROM_ATT) begin
                     next_state.gate = GATE_ATTACK;
                     phase_inc = att_pos;
                  end else begin
                     phase_inc = rel_neg;
                  end
               end
               GATE_GATED: begin
                  if (!trig_level) begin
                     next_state.gate = GATE_RELEASE;
                     phase_inc = rel_pos;
                  end
               end
               GATE_RELEASE: begin
                  if (trig_level) begin
                     next_state.gate = GATE_RETRIGGER;
                     phase_inc = att_neg;
                  end else if (phase_event == EV_A_FROM_REL) begin
                     next_state.gate = GATE_ATTACK;
                     phase_inc = att_pos;
                  end else begin
                     phase_inc = rel_pos;
                  end
               end
               GATE_RETRIGGER: begin
                  if (!gate_level || phase_event == EV_B_FROM_REL) begin
                     next_state.gate = GATE_RELEASE;
                     phase_inc = rel_pos;
                  end else begin
                     phase_inc = att_neg;
                  end
               end
               default: begin
                  next_state.gate = GATE_ATTACK;
                  if (!gate_level) begin
                     next_state.gate = GATE_REL_REVERSE;
                     phase_inc = rel_neg;
                  end else if (phase_event == EV_B_FROM_ATT) begin
                     next_state.gate = GATE_GATED;
                  end else begin
                     phase_inc = att_pos;
                  end
               end
            endcase
            active_state = next_state.gate;
         end
         MODE_PENDULUM: begin
            case (cur_state.pendulum)
               PEND_FWD_ATTACK: begin
                  if (!trig_level && osc_active) begin
                     next_state.pendulum = PEND_REV_ATTACK;
                  end else if (phase_event == EV_B_FROM_ATT) begin
                     next_state.pendulum = PEND_FWD_RELEASE;
                     phase_inc = rel_pos;
                  end else begin
                     phase_inc = att_pos;
                  end
               end
               PEND_REV_ATTACK: begin
                  if (!trig_level) begin
                     next_state.pendulum = PEND_FWD_ATTACK;
                     phase_inc = att_pos;
                  end else if (phase_event == EV_A_FROM_ATT) begin
                     next_state.pendulum = PEND_REV_RELEASE;
                     phase_inc = rel_neg;
                  end else begin
                     phase_inc = att_neg;
                  end
               end
               PEND_FWD_RELEASE: begin
                  if (!trig_level) begin
                     next_state.pendulum = PEND_REV_RELEASE;
                     phase_inc = rel_neg;
                  end else if (phase_event == EV_A_FROM_REL) begin
                     next_state.pendulum = PEND_FWD_ATTACK;
                     phase_inc = att_pos;
                  end else begin
                     phase_inc = rel_pos;
                  end
               end
               PEND_REV_RELEASE: begin
                  if (!trig_level) begin
                     next_state.pendulum = PEND_FWD_RELEASE;
                     phase_inc = rel_pos;
                  end else if (phase_event == EV_B_FROM_REL) begin
                     next_state.pendulum = PEND_REV_ATTACK;
                     phase_inc = att_neg;
                  end else begin
                     phase_inc = rel_neg;
                  end
               end
               default: begin
                  next_state.pendulum = PEND_RESTING;
                  if (!trig_level) begin
                     next_state.pendulum = PEND_FWD_ATTACK;
                     phase_inc = att_pos;
                  end
               end
            endcase
            active_state = next_state.pendulum;
         end
         default: begin
            // Unused mode: hold all state, emit zero
            phase_inc    = '0;
            active_state = '0;
         end
      endcase
   end

endmodule

>>> rtl/trigger_mode_sequencer_unit.sv
// Top level of the trigger mode sequencer: input register, machine state,
// result register and configuration registers. Depends on tms_pkg, tms_step.
//
// Usage:
//  - req_ channel: one beat per audio sample tick, carrying the trigger level,
//    phase event, oscillator flag and the attack and release increments.
//  - rsp_ channel: one beat per request beat, in order, carrying the signed
//    phase increment and the state index of the selected machine.
//  - csr_ channel: index 0 writes trig_mode, index 1 writes gate_hold;
//    csr_ready is always high. Write only while no beat is in flight.
// Flow: a request beat accepted is captured in the input register, moves into the
// result register and is then offered on rsp_.
// Throughput: one beat per cycle while rsp_ready does not stall the result,
// set by the state update of the selected machine.
// Reset: synchronous, active high; empties both registers, sets trig_mode and
// gate_hold to 0 and puts every machine in its attack state (pendulum rests).
// Stall: while rsp_ready is low the result holds; the input register still takes
// one beat if it is empty, and req_ready then stays low while it holds that beat.
module trigger_mode_sequencer_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_trig_level,
   input  logic [tms_pkg::EVENT_W-1:0]         req_phase_event,
   input  logic                                req_osc_active,
   input  logic [tms_pkg::INC_WIDTH-1:0]       req_attack_inc,
   input  logic [tms_pkg::INC_WIDTH-1:0]       req_release_inc,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [tms_pkg::PHASE_W-1:0]  rsp_phase_inc,
   output logic [tms_pkg::STATE_W-1:0]         rsp_active_state,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [tms_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [tms_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import tms_pkg::*;

   logic [MODE_W-1:0]     trig_mode_ff;
   logic                  gate_hold_ff;

   logic                  stage_valid_ff;
   logic                  stage_level_ff;
   logic [EVENT_W-1:0]    stage_event_ff;
   logic                  stage_osc_ff;
   logic [INC_WIDTH-1:0]  stage_att_ff;
   logic [INC_WIDTH-1:0]  stage_rel_ff;

   seq_state_type         seq_state_ff;
   seq_state_type         seq_state_in;

   logic                  rsp_valid_ff;
   logic [PHASE_W-1:0]    rsp_phase_ff;
   logic [PHASE_W-1:0]    rsp_phase_in;
   logic [STATE_W-1:0]    rsp_state_ff;
   logic [STATE_W-1:0]    rsp_state_in;

   logic                  req_take;
   logic                  rsp_load;

   // Handshake: the result register frees the input register
   assign rsp_load  = stage_valid_ff & (~rsp_valid_ff | rsp_ready);
   assign req_ready = ~stage_valid_ff | rsp_load;
   assign req_take  = req_valid & req_ready;
   assign csr_ready = 1'b1;

   // Sequencer step on the registered beat
   tms_step u_step (
      .trig_mode    (trig_mode_ff),
      .gate_hold    (gate_hold_ff),
      .cur_state    (seq_state_ff),
      .trig_level   (stage_level_ff),
      .phase_event  (stage_event_ff),
      .osc_active   (stage_osc_ff),
      .attack_inc   (stage_att_ff),
      .release_inc  (stage_rel_ff),
      .next_state   (seq_state_in),
      .phase_inc    (rsp_phase_in),
      .active_state (rsp_state_in)
   );

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         trig_mode_ff <= MODE_NORETRIG;
         gate_hold_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_TRIG_MODE: trig_mode_ff <= csr_wdata[MODE_W-1:0];
            REG_GATE_HOLD: gate_hold_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Input register: capture a beat whenever the stage is free or moves on to the result
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else if (req_ready) begin
         stage_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         stage_level_ff <= req_trig_level;
         stage_event_ff <= req_phase_event;
         stage_osc_ff   <= req_osc_active;
         stage_att_ff   <= req_attack_inc;
         stage_rel_ff   <= req_release_inc;
      end
   end

   // Machine state: advance once per beat moved to the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         seq_state_ff.noretrig <= TWO_ATTACK;
         seq_state_ff.hardsync <= TWO_ATTACK;
         seq_state_ff.envelope <= ENV_ATTACK;
         seq_state_ff.gate     <= GATE_ATTACK;
         seq_state_ff.pendulum <= PEND_RESTING;
      end else if (rsp_load) begin
         seq_state_ff <= seq_state_in;
      end
   end

   // Result register: hold while the receiver stalls
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_phase_ff <= rsp_phase_in;
         rsp_state_ff <= rsp_state_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_phase_inc    = $signed(rsp_phase_ff);
   assign rsp_active_state = rsp_state_ff;

   // A taken request beat always lands in the input register
   a_req_lands: assert property (@(posedge clock) disable iff (reset)
      req_take |=> stage_valid_ff)
      else $error("accepted request beat lost");

   // A blocked beat in the input register is kept
   a_stage_holds: assert property (@(posedge clock) disable iff (reset)
      (stage_valid_ff && !rsp_load) |=> stage_valid_ff)
      else $error("blocked beat dropped from input register");

   // Reported state index stays within the machine codes
   a_state_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_state_ff <= PEND_REV_RELEASE))
      else $error("state index out of range");

   // Increment never reaches the most negative code
   a_inc_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_phase_ff != {1'b1, {INC_WIDTH{1'b0}}}))
      else $error("phase increment out of range");

endmodule

>>> tb/sv/tb_trigger_mode_sequencer_unit.sv
// Self-checking testbench for trigger_mode_sequencer_unit: directed table, then random
// phases with idle, stall and back-pressure, checked against a local machine predictor.
// Depends on tms_pkg and the trigger_mode_sequencer_unit RTL.
module tb_trigger_mode_sequencer_unit;
   import tms_pkg::*;

   localparam int CLK_HALF     = 6;
   localparam int RESET_CYCLES = 7;
   localparam int QUIET_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 4;
   localparam int HOLD_CYCLES  = 64;
   localparam int PHASES       = 20;
   localparam int PHASE_BEATS  = 100;
   localparam int REPORT_MAX   = 10;
   localparam int DIR_ROWS     = 31;

   // Codes that the package leaves unnamed
   localparam logic [EVENT_W-1:0]    EV_NONE           = 3'd0;
   localparam logic [EVENT_W-1:0]    EV_UNUSED_FIRST   = 3'd5;
   localparam logic [EVENT_W-1:0]    EV_UNUSED_LAST    = 3'd7;
   localparam logic [MODE_W-1:0]     MODE_UNUSED_FIRST = 3'd5;
   localparam logic [MODE_W-1:0]     MODE_UNUSED_MID   = 3'd6;
   localparam logic [MODE_W-1:0]     MODE_UNUSED_LAST  = 3'd7;
   localparam logic [CSR_DATA_W-1:0] LOOP_OFF          = 3'd0;
   localparam logic [CSR_DATA_W-1:0] LOOP_ON           = 3'd1;

   localparam logic [INC_WIDTH-1:0]      INC_ALL    = '1;
   localparam logic [INC_WIDTH-1:0]      INC_NONE   = '0;
   localparam logic signed [PHASE_W-1:0] PHASE_ZERO = '0;
   localparam logic signed [PHASE_W-1:0] INC_MAX    = $signed({1'b0, INC_ALL});
   localparam logic signed [PHASE_W-1:0] NEG_MAX    = -INC_MAX;
   localparam logic [STATE_W-1:0]        ST_TWO_ATT = STATE_W'(TWO_ATTACK);
   localparam logic [STATE_W-1:0]        ST_TWO_REL = STATE_W'(TWO_RELEASE);
   localparam logic [STATE_W-1:0]        ST_ENV_RTG = STATE_W'(ENV_RETRIGGER);
   localparam logic [STATE_W-1:0]        ST_UNUSED  = '0;

   typedef struct packed {
      logic                 lvl;
      logic [EVENT_W-1:0]   ev;
      logic                 osc;
      logic [INC_WIDTH-1:0] att;
      logic [INC_WIDTH-1:0] rel;
   } tick_type;

   typedef struct packed {
      logic signed [PHASE_W-1:0] phase;
      logic [STATE_W-1:0]        state;
   } phase_step_type;

   typedef struct packed {
      logic [CSR_IDX_W-1:0]  idx;
      logic [CSR_DATA_W-1:0] data;
   } reg_write_type;

   typedef enum logic {ROW_BEAT, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type   kind;
      tick_type       tick;
      logic           pinned;
      phase_step_type pin;
      reg_write_type  wr;
   } dir_row_type;

   localparam tick_type       NO_TICK = '0;
   localparam phase_step_type NO_PIN  = '0;
   localparam reg_write_type  NO_CSR  = '0;

   // Directed walk: each machine through its main transitions, pinned where obvious
   localparam dir_row_type DIRECTED_ROWS [DIR_ROWS] = '{
      // no-retrigger after reset: max attack, unused event, release at B
      '{ROW_BEAT, '{1'b1, EV_NONE, 1'b0, INC_ALL, INC_NONE}, 1'b1, '{INC_MAX, ST_TWO_ATT}, NO_CSR},
      '{ROW_BEAT, '{1'b0, EV_UNUSED_LAST, 1'b1, INC_NONE, INC_ALL}, 1'b1,
        '{PHASE_ZERO, ST_TWO_ATT}, NO_CSR},
      '{ROW_BEAT, '{1'b1, EV_B_FROM_ATT, 1'b0, 24'h5A5A5A, INC_ALL}, 1'b1,
        '{INC_MAX, ST_TWO_REL}, NO_CSR},
      '{ROW_BEAT, '{1'b1, EV_A_FROM_REL, 1'b0, 24'hA5A5A5, 24'h5A5A5A}, 1'b0, NO_PIN, NO_CSR},
      // hard sync: trigger in release keeps the release step, then trigger with event at A
      '{ROW_CSR, NO_TICK, 1'b0, NO_PIN, '{REG_TRIG_MODE, MODE_HARDSYNC}},
      '{ROW_BEAT, '{1'b1, EV_B_FROM_ATT, 1'b0, 24'h000001, 24'h800000}, 1'b0, NO_PIN, NO_CSR},
      '{ROW_BEAT, '{1'b0, EV_NONE, 1'b0, 24'h123456, 24'h654321}, 1'b0, NO_PIN, NO_CSR},
      '{ROW_BEAT, '{1'b1, EV_B_FROM_ATT, 1'b1, 24'h0F0F0F, 24'hF0F0F0}, 1'b0, NO_PIN, NO_CSR},
      '{ROW_BEAT, '{1'b0, EV_A_FROM_REL, 1'b0, 24'hFFFFFE, 24'h000002}, 1'b0, NO_PIN, NO_CSR},
      // envelope: release, retrigger with negative max attack, back through release
      '{ROW_CSR, NO_TICK, 1'b0, NO_PIN, '{REG_TRIG_MODE, MODE_ENVELOPE}},
      '{ROW_BEAT, '{1'b1, EV_B_FROM_ATT, 1'b0, 24'h333333, 24'hCCCCCC}, 1'b0, NO_PIN, NO_CSR},
      '{ROW_BEAT, '{1'b0, EV_NONE, 1'b0, INC_ALL, INC_NONE}, 1'b1, '{NEG_MAX, ST_ENV_RTG}, NO_CSR},
      '{ROW_BEAT, '{1'b1, EV_B_FROM_REL, 1'b0, 24'h00FF00, 24'hFF00FF}, 1'b0, NO_PIN, NO_CSR},
      '{ROW_BEAT, '{1'b1, EV_A_FROM_REL, 1'b1, 24'h7FFFFF, 24'h800001}, 1'b0, NO_PIN, NO_CSR},
      // gate without loop: every state of the machine
      '{ROW_CSR, NO_TICK, 1'b0, NO_PIN, '{REG_TRIG_MODE, MODE_GATE}},
      '{ROW_BEAT, '{1'b0, EV_NONE, 1'b0, 24'h111111, INC_ALL}, 1'b0, NO_PIN, NO_CSR},
      '{ROW_BEAT, '{1'b0, EV_A_FROM_ATT, 1'b0, 24'h222222, 24'h444444}, 1'b0, NO_PIN, NO_CSR},
      '{ROW_BEAT, '{1'b1, EV_B_FROM_ATT, 1'b0, 24'h555555, 24'hAAAAAA}, 1'b0, NO_PIN, NO_CSR},
      '{ROW_BEAT, '{1'b0, EV_NONE, 1'b0, 24'h010203, 24'h040506}, 1'b0, NO_PIN, NO_CSR},
      '{ROW_BEAT, '{1'b1, EV_NONE, 1'b0, 24'hABCDEF, 24'hFEDCBA}, 1'b0, NO_PIN, NO_CSR},
      '{ROW_BEAT, '{1'b1, EV_B_FROM_REL, 1'b0, 24'h0000FF, 24'hFF0000}, 1'b0, NO_PIN, NO_CSR},
      '{ROW_BEAT, '{1'b1, EV_A_FROM_REL, 1'b0, 24'h00FFFF, 24'hFFFF00}, 1'b0, NO_PIN, NO_CSR},
      // loop on: a dropped gate no longer reverses the attack
      '{ROW_CSR, NO_TICK, 1'b0, NO_PIN, '{REG_GATE_HOLD, LOOP_ON}},
      '{ROW_BEAT, '{1'b0, EV_NONE, 1'b0, 24'h765432, 24'h234567}, 1'b0, NO_PIN, NO_CSR},
      // pendulum: rest, forward, reverse with the oscillator running, reverse release
      '{ROW_CSR, NO_TICK, 1'b0, NO_PIN, '{REG_TRIG_MODE, MODE_PENDULUM}},
      '{ROW_BEAT, '{1'b1, EV_NONE, 1'b1, 24'h0A0A0A, 24'hA0A0A0}, 1'b0, NO_PIN, NO_CSR},
      '{ROW_BEAT, '{1'b0, EV_NONE, 1'b0, 24'h13579B, 24'h2468AC}, 1'b0, NO_PIN, NO_CSR},
      '{ROW_BEAT, '{1'b0, EV_NONE, 1'b1, 24'h888888, 24'h777777}, 1'b0, NO_PIN, NO_CSR},
      '{ROW_BEAT, '{1'b1, EV_A_FROM_ATT, 1'b0, 24'h999999, INC_ALL}, 1'b0, NO_PIN, NO_CSR},
      // unused mode: zero step and state, nothing moves
      '{ROW_CSR, NO_TICK, 1'b0, NO_PIN, '{REG_TRIG_MODE, MODE_UNUSED_LAST}},
      '{ROW_BEAT, '{1'b0, EV_B_FROM_ATT, 1'b1, INC_ALL, INC_ALL}, 1'b1,
        '{PHASE_ZERO, ST_UNUSED}, NO_CSR}
   };

   // Mode per random phase, the unused codes included
   localparam logic [MODE_W-1:0] PHASE_MODES [PHASES] = '{
      MODE_NORETRIG, MODE_HARDSYNC, MODE_ENVELOPE, MODE_GATE, MODE_PENDULUM,
      MODE_GATE, MODE_PENDULUM, MODE_ENVELOPE, MODE_UNUSED_FIRST, MODE_HARDSYNC,
      MODE_NORETRIG, MODE_GATE, MODE_PENDULUM, MODE_UNUSED_MID, MODE_ENVELOPE,
      MODE_GATE, MODE_PENDULUM, MODE_UNUSED_LAST, MODE_HARDSYNC, MODE_NORETRIG
   };

   logic                       clock            = 1'b0;
   logic                       reset            = 1'b1;
   logic                       req_valid        = 1'b0;
   logic                       req_ready;
   logic                       req_trig_level   = 1'b0;
   logic [EVENT_W-1:0]         req_phase_event  = '0;
   logic                       req_osc_active   = 1'b0;
   logic [INC_WIDTH-1:0]       req_attack_inc   = '0;
   logic [INC_WIDTH-1:0]       req_release_inc  = '0;
   logic                       rsp_valid;
   logic                       rsp_ready        = 1'b0;
   logic signed [PHASE_W-1:0]  rsp_phase_inc;
   logic [STATE_W-1:0]         rsp_active_state;
   logic                       csr_valid        = 1'b0;
   logic                       csr_ready;
   logic [CSR_IDX_W-1:0]       csr_index        = '0;
   logic [CSR_DATA_W-1:0]      csr_wdata        = '0;

   // Typed expectation that travels with the request beat
   logic                       beat_pinned      = 1'b0;
   phase_step_type             beat_pin         = '0;

   // Receiver controls
   int                         stall_pct        = 0;
   int                         hold_requests    = 0;
   int                         hold_served      = 0;
   int                         hold_left        = 0;

   // Predictor copy of registers and machines
   logic [MODE_W-1:0]          mode_mirror      = MODE_NORETRIG;
   logic                       loop_mirror      = 1'b0;
   seq_state_type              seq_mirror       = '0;

   phase_step_type             pending_steps[$];
   int                         error_count      = 0;
   int                         quiet_cycles     = 0;

   trigger_mode_sequencer_unit u_top (.*);

   initial begin
      forever #CLK_HALF clock = ~clock;
   end

   // Step the selected machine once and return the signed increment and its state
   function automatic phase_step_type advance_sequencer(input tick_type t);
      logic signed [PHASE_W-1:0] att_up;
      logic signed [PHASE_W-1:0] att_dn;
      logic signed [PHASE_W-1:0] rel_up;
      logic signed [PHASE_W-1:0] rel_dn;
      logic                      gate_held;
      phase_step_type            res;
      att_up    = $signed({1'b0, t.att});
      rel_up    = $signed({1'b0, t.rel});
      att_dn    = -att_up;
      rel_dn    = -rel_up;
      gate_held = t.lvl || loop_mirror;
      // branches that leave phase alone emit a zero step
      res       = '0;
      case (mode_mirror)
         MODE_NORETRIG: begin
            if (seq_mirror.noretrig == TWO_RELEASE) begin
               if (t.ev == EV_A_FROM_REL) begin
                  seq_mirror.noretrig = TWO_ATTACK;
                  res.phase = att_up;
               end else begin
                  res.phase = rel_up;
               end
            end else if (t.ev == EV_B_FROM_ATT) begin
               seq_mirror.noretrig = TWO_RELEASE;
               res.phase = rel_up;
            end else begin
               res.phase = att_up;
            end
            res.state = STATE_W'(seq_mirror.noretrig);
         end
         MODE_HARDSYNC: begin
            if (seq_mirror.hardsync == TWO_RELEASE) begin
               // a fired trigger restarts attack but keeps the release step this tick
               if (!t.lvl) seq_mirror.hardsync = TWO_ATTACK;
               if (t.ev == EV_A_FROM_REL) begin
                  seq_mirror.hardsync = TWO_ATTACK;
                  res.phase = att_up;
               end else begin
                  res.phase = rel_up;
               end
            end else if (t.ev == EV_B_FROM_ATT) begin
               seq_mirror.hardsync = TWO_RELEASE;
               res.phase = rel_up;
            end else begin
               res.phase = att_up;
            end
            res.state = STATE_W'(seq_mirror.hardsync);
         end
         MODE_ENVELOPE: begin
            case (seq_mirror.envelope)
               ENV_RELEASE: begin
                  if (!t.lvl) begin
                     seq_mirror.envelope = ENV_RETRIGGER;
                     res.phase = att_dn;
                  end else if (t.ev == EV_A_FROM_REL) begin
                     seq_mirror.envelope = ENV_ATTACK;
                     res.phase = att_up;
                  end else begin
                     res.phase = rel_up;
                  end
               end
               ENV_RETRIGGER: begin
                  if (t.ev == EV_B_FROM_REL) begin
                     seq_mirror.envelope = ENV_RELEASE;
                     res.phase = rel_up;
                  end else begin
                     res.phase = att_dn;
                  end
               end
               default: begin
                  seq_mirror.envelope = ENV_ATTACK;
                  if (t.ev == EV_B_FROM_ATT) begin
                     seq_mirror.envelope = ENV_RELEASE;
                     res.phase = rel_up;
                  end else begin
                     res.phase = att_up;
                  end
               end
            endcase
            res.state = STATE_W'(seq_mirror.envelope);
         end
         MODE_GATE: begin
            case (seq_mirror.gate)
               GATE_REL_REVERSE: begin
                  if (t.lvl || t.ev == EV_A_FROM_ATT) begin
                     seq_mirror.gate = GATE_ATTACK;
                     res.phase = att_up;
                  end else begin
                     res.phase = rel_dn;
                  end
               end
               GATE_GATED: begin
                  if (!t.lvl) begin
                     seq_mirror.gate = GATE_RELEASE;
                     res.phase = rel_up;
                  end
               end
               GATE_RELEASE: begin
                  if (t.lvl) begin
                     seq_mirror.gate = GATE_RETRIGGER;
                     res.phase = att_dn;
                  end else if (t.ev == EV_A_FROM_REL) begin
                     seq_mirror.gate = GATE_ATTACK;
                     res.phase = att_up;
                  end else begin
                     res.phase = rel_up;
                  end
               end
               GATE_RETRIGGER: begin
                  if (!gate_held || t.ev == EV_B_FROM_REL) begin
                     seq_mirror.gate = GATE_RELEASE;
                     res.phase = rel_up;
                  end else begin
                     res.phase = att_dn;
                  end
               end
               default: begin
                  seq_mirror.gate = GATE_ATTACK;
                  if (!gate_held) begin
                     seq_mirror.gate = GATE_REL_REVERSE;
                     res.phase = rel_dn;
                  end else if (t.ev == EV_B_FROM_ATT) begin
                     seq_mirror.gate = GATE_GATED;
                  end else begin
                     res.phase = att_up;
                  end
               end
            endcase
            res.state = seq_mirror.gate;
         end
         MODE_PENDULUM: begin
            case (seq_mirror.pendulum)
               PEND_FWD_ATTACK: begin
                  if (!t.lvl && t.osc) begin
                     seq_mirror.pendulum = PEND_REV_ATTACK;
                  end else if (t.ev == EV_B_FROM_ATT) begin
                     seq_mirror.pendulum = PEND_FWD_RELEASE;
                     res.phase = rel_up;
                  end else begin
                     res.phase = att_up;
                  end
               end
               PEND_REV_ATTACK: begin
                  if (!t.lvl) begin
                     seq_mirror.pendulum = PEND_FWD_ATTACK;
                     res.phase = att_up;
                  end else if (t.ev == EV_A_FROM_ATT) begin
                     seq_mirror.pendulum = PEND_REV_RELEASE;
                     res.phase = rel_dn;
                  end else begin
                     res.phase = att_dn;
                  end
               end
               PEND_FWD_RELEASE: begin
                  if (!t.lvl) begin
                     seq_mirror.pendulum = PEND_REV_RELEASE;
                     res.phase = rel_dn;
                  end else if (t.ev == EV_A_FROM_REL) begin
                     seq_mirror.pendulum = PEND_FWD_ATTACK;
                     res.phase = att_up;
                  end else begin
                     res.phase = rel_up;
                  end
               end
               PEND_REV_RELEASE: begin
                  if (!t.lvl) begin
                     seq_mirror.pendulum = PEND_FWD_RELEASE;
                     res.phase = rel_up;
                  end else if (t.ev == EV_B_FROM_REL) begin
                     seq_mirror.pendulum = PEND_REV_ATTACK;
                     res.phase = att_dn;
                  end else begin
                     res.phase = rel_dn;
                  end
               end
               default: begin
                  seq_mirror.pendulum = PEND_RESTING;
                  if (!t.lvl) begin
                     seq_mirror.pendulum = PEND_FWD_ATTACK;
                     res.phase = att_up;
                  end
               end
            endcase
            res.state = seq_mirror.pendulum;
         end
         default: begin
            // unused mode: zero step, zero state, no machine moves
         end
      endcase
      return res;
   endfunction

   // Mostly random magnitudes, with both extremes mixed in
   function automatic logic [INC_WIDTH-1:0] random_inc();
      case ($urandom_range(9))
         0: return INC_ALL;
         1: return INC_NONE;
         default: return INC_WIDTH'($urandom);
      endcase
   endfunction

   // Track register writes, check result beats, predict request beats
   always @(posedge clock) begin
      phase_step_type got;
      phase_step_type want;
      if (reset) begin
         mode_mirror = MODE_NORETRIG;
         loop_mirror = 1'b0;
         seq_mirror  = '{noretrig: TWO_ATTACK, hardsync: TWO_ATTACK, envelope: ENV_ATTACK,
                         gate: GATE_ATTACK, pendulum: PEND_RESTING};
         pending_steps.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_TRIG_MODE: mode_mirror = csr_wdata[MODE_W-1:0];
               REG_GATE_HOLD: loop_mirror = csr_wdata[0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_phase_inc, rsp_active_state};
            if (pending_steps.size() == 0) begin
               error_count++;
               if (error_count <= REPORT_MAX)
                  $display("unexpected result beat: phase_inc %0d active_state %0d",
                           got.phase, got.state);
            end else begin
               want = pending_steps.pop_front();
               if (got.phase !== want.phase || got.state !== want.state) begin
                  error_count++;
                  if (error_count <= REPORT_MAX)
                     $display("mismatch: phase_inc exp %0d got %0d, active_state exp %0d got %0d",
                              want.phase, got.phase, want.state, got.state);
               end
            end
         end
         if (req_valid && req_ready) begin
            want = advance_sequencer('{req_trig_level, req_phase_event, req_osc_active,
                                       req_attack_inc, req_release_inc});
            if (beat_pinned) want = beat_pin;
            pending_steps.push_back(want);
         end
      end
   end

   // Receiver: long hold-off on request, otherwise random stalls
   always @(posedge clock) begin
      if (hold_served != hold_requests) begin
         hold_served <= hold_requests;
         hold_left   <= HOLD_CYCLES;
         rsp_ready   <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // Watchdog: end the run after too long without any beat
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("trigger_mode_sequencer_unit test failed");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   // Drop valid and wait until every predicted step has come back
   task automatic await_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_steps.size() != 0) @(posedge clock);
   endtask

   // Write one register once the block is idle
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      await_idle();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // Offer one sample tick after a random gap; return at the accepting edge
   task automatic offer_tick(input tick_type t, input logic pinned, input phase_step_type pin,
                             input int gap_pct);
      while ($urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_trig_level  <= t.lvl;
      req_phase_event <= t.ev;
      req_osc_active  <= t.osc;
      req_attack_inc  <= t.att;
      req_release_inc <= t.rel;
      beat_pinned     <= pinned;
      beat_pin        <= pin;
      do @(posedge clock); while (!req_ready);
   endtask

   initial begin
      tick_type tick;
      int       gap_pct;
      int       pick;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed table
      for (int i = 0; i < DIR_ROWS; i++) begin
         if (DIRECTED_ROWS[i].kind == ROW_CSR)
            write_reg(DIRECTED_ROWS[i].wr.idx, DIRECTED_ROWS[i].wr.data);
         else
            offer_tick(DIRECTED_ROWS[i].tick, DIRECTED_ROWS[i].pinned, DIRECTED_ROWS[i].pin, 0);
      end

      // Random phases: new settings, idle pattern, occasional long receiver hold-off
      for (int ph = 0; ph < PHASES; ph++) begin
         write_reg(REG_TRIG_MODE, PHASE_MODES[ph]);
         write_reg(REG_GATE_HOLD, $urandom_range(1) ? LOOP_ON : LOOP_OFF);
         case (ph % 4)
            0: begin gap_pct = 0;  stall_pct = 0;  end
            1: begin gap_pct = 49; stall_pct = 0;  end
            2: begin gap_pct = 0;  stall_pct = 49; end
            default: begin gap_pct = 17; stall_pct = 17; end
         endcase
         if (ph % 7 == 4) hold_requests++;
         repeat (PHASE_BEATS) begin
            tick.lvl = ($urandom_range(99) < 70);
            pick     = $urandom_range(99);
            if (pick < 65)
               tick.ev = EVENT_W'($urandom_range(EV_B_FROM_REL, EV_A_FROM_ATT));
            else if (pick < 90)
               tick.ev = EV_NONE;
            else
               tick.ev = EVENT_W'($urandom_range(EV_UNUSED_LAST, EV_UNUSED_FIRST));
            tick.osc = 1'($urandom_range(1));
            tick.att = random_inc();
            tick.rel = random_inc();
            offer_tick(tick, 1'b0, NO_PIN, gap_pct);
         end
      end

      // Drain, let the pipeline settle, then report
      await_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && pending_steps.size() == 0) begin
         $display("trigger_mode_sequencer_unit test passed");
      end else begin
         $display("trigger_mode_sequencer_unit test failed");
      end
      $finish;
   end

endmodule
